FILE: hdl/v4au_pkg.sv
// shared definitions for the four-lane vector arithmetic unit
// opcode and status codes, default lane format, per-lane flag type
// no dependencies
package v4au_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PORT_BITS     = 32;
	localparam int LANES         = 4;
	// sums of squares at or above 2**SUM_LIMIT count as overflow
	localparam int SUM_LIMIT     = 128;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_ADDS = 4'd4,
		OP_SUBS = 4'd5,
		OP_MULS = 4'd6,
		OP_DIVS = 4'd7,
		OP_NEG  = 4'd8,
		OP_EQ   = 4'd9,
		OP_NE   = 4'd10,
		OP_LEN  = 4'd11,
		OP_NORM = 4'd12
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIVZ = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic sat;
		logic dz;
	} lane_flag_t;

endpackage

FILE: hdl/v4au_lane.sv
// one arithmetic lane: unpack, add/sub/negate, multiply, divide-by-zero check
// two pipeline stages; uses v4au_pkg
// feeds the sum-of-squares merge and the per-lane divide path in the top level
module v4au_lane #(
	parameter int WORD_BITS = v4au_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = v4au_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  v4au_pkg::opcode_t          op,
	input  logic [WORD_BITS-1:0]       ra,
	input  logic [WORD_BITS-1:0]       rb,
	output logic [WORD_BITS-1:0]       res_s3,
	output v4au_pkg::lane_flag_t       flg_s3,
	output logic                       na_s3,
	output logic                       nb_s3,
	output logic [WORD_BITS-1:0]       ma_s3,
	output logic [WORD_BITS-1:0]       mb_s3,
	output logic [2*WORD_BITS-1:0]     prod_s3
);

	localparam int W = WORD_BITS;
	localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINM = {1'b1, {(W-1){1'b0}}};

	logic              na_c, nb_c;
	logic [W-1:0]      ma_c, mb_c, mop_c, res_c;
	logic [W:0]        as_c;
	logic [2*W-1:0]    prod_c;
	v4au_pkg::lane_flag_t flg_c;

	v4au_pkg::opcode_t    op_s2;
	logic [W-1:0]         res_s2, ma_s2, mb_s2;
	logic                 na_s2, nb_s2;
	logic [2*W-1:0]       prod_s2;
	v4au_pkg::lane_flag_t flg_s2;

	logic [2*W-1:0]       mag_c;
	logic [W-1:0]         res2_c;
	logic                 msat_c;

	always_comb begin
		na_c   = ra[W-1];
		nb_c   = rb[W-1];
		ma_c   = na_c ? -ra : ra;
		mb_c   = nb_c ? -rb : rb;
		// length and normalize reuse the multiplier for squares
		mop_c  = (op == v4au_pkg::OP_LEN || op == v4au_pkg::OP_NORM) ? ma_c : mb_c;
		prod_c = (2*W)'(ma_c) * (2*W)'(mop_c);
		as_c   = '0;
		res_c  = '0;
		flg_c  = '0;
		case (op)
			v4au_pkg::OP_ADD, v4au_pkg::OP_ADDS: begin
				as_c = {ra[W-1], ra} + {rb[W-1], rb};
				if (as_c[W] != as_c[W-1]) begin
					flg_c.sat = 1'b1;
					res_c     = as_c[W] ? MINM : MAXP;
				end else begin
					res_c = as_c[W-1:0];
				end
			end
			v4au_pkg::OP_SUB, v4au_pkg::OP_SUBS: begin
				as_c = {ra[W-1], ra} - {rb[W-1], rb};
				if (as_c[W] != as_c[W-1]) begin
					flg_c.sat = 1'b1;
					res_c     = as_c[W] ? MINM : MAXP;
				end else begin
					res_c = as_c[W-1:0];
				end
			end
			v4au_pkg::OP_DIV, v4au_pkg::OP_DIVS: begin
				if (mb_c == '0) begin
					flg_c.dz = 1'b1;
					res_c    = na_c ? MINM : MAXP;
				end
			end
			v4au_pkg::OP_NEG: begin
				if (ra == MINM) begin
					flg_c.sat = 1'b1;
					res_c     = MAXP;
				end else begin
					res_c = -ra;
				end
			end
			// zero vector passes through unchanged
			v4au_pkg::OP_NORM: res_c = ra;
			default:           res_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op;
			res_s2  <= res_c;
			flg_s2  <= flg_c;
			na_s2   <= na_c;
			nb_s2   <= nb_c;
			ma_s2   <= ma_c;
			mb_s2   <= mb_c;
			prod_s2 <= prod_c;
		end
	end

	// product scaling and saturation
	always_comb begin
		mag_c  = prod_s2 >> FRAC_BITS;
		res2_c = res_s2;
		msat_c = 1'b0;
		if (op_s2 == v4au_pkg::OP_MUL || op_s2 == v4au_pkg::OP_MULS) begin
			if (na_s2 != nb_s2) begin
				if (mag_c > (2*W)'(MINM)) begin
					msat_c = 1'b1;
					res2_c = MINM;
				end else begin
					res2_c = -mag_c[W-1:0];
				end
			end else begin
				if (mag_c > (2*W)'(MAXP)) begin
					msat_c = 1'b1;
					res2_c = MAXP;
				end else begin
					res2_c = mag_c[W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3     <= res2_c;
			flg_s3.sat <= flg_s2.sat | msat_c;
			flg_s3.dz  <= flg_s2.dz;
			na_s3      <= na_s2;
			nb_s3      <= nb_s2;
			ma_s3      <= ma_s2;
			mb_s3      <= mb_s2;
			prod_s3    <= prod_s2;
		end
	end

endmodule

FILE: hdl/v4au_isqrt.sv
// pipelined integer square root, one result bit per stage
// floor root of a 2*WORD_BITS+2 bit value; default width from v4au_pkg
module v4au_isqrt #(
	parameter int WORD_BITS = v4au_pkg::WORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [2*WORD_BITS+1:0] val,
	output logic [WORD_BITS:0]     root
);

	localparam int W     = WORD_BITS;
	localparam int VW    = 2*W + 2;
	localparam int STEPS = W + 1;
	localparam int RW    = W + 2;

	logic [RW-1:0] rem_q  [STEPS];
	logic [W:0]    root_q [STEPS];
	logic [VW-1:0] val_q  [STEPS];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		logic [RW-1:0] rem_i;
		logic [W:0]    root_i;
		logic [VW-1:0] val_i;
		logic [RW+1:0] rs, trial;

		if (j == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign val_i  = val;
		end else begin : g_next
			assign rem_i  = rem_q[j-1];
			assign root_i = root_q[j-1];
			assign val_i  = val_q[j-1];
		end

		always_comb begin
			rs    = {rem_i, val_i[VW-1 -: 2]};
			trial = (RW+2)'({root_i, 2'b01});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rs >= trial) begin
					rem_q[j]  <= RW'(rs - trial);
					root_q[j] <= {root_i[W-1:0], 1'b1};
				end else begin
					rem_q[j]  <= RW'(rs);
					root_q[j] <= {root_i[W-1:0], 1'b0};
				end
				val_q[j] <= val_i << 2;
			end
		end
	end

	assign root = root_q[STEPS-1];

endmodule

FILE: hdl/v4au_div.sv
// pipelined restoring divider for one lane, one quotient bit per stage
// unsigned (WORD_BITS+FRAC_BITS)-bit dividend by (WORD_BITS+1)-bit divisor
module v4au_div #(
	parameter int WORD_BITS = v4au_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = v4au_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [WORD_BITS+FRAC_BITS-1:0] num,
	input  logic [WORD_BITS:0]             den,
	output logic [WORD_BITS+FRAC_BITS-1:0] quo
);

	localparam int NW = WORD_BITS + FRAC_BITS;
	localparam int DW = WORD_BITS + 1;

	logic [DW-1:0] rem_q [NW];
	logic [NW-1:0] n_q   [NW];
	logic [DW-1:0] d_q   [NW];

	for (genvar j = 0; j < NW; j++) begin : g_step
		logic [DW-1:0] rem_i, d_i;
		logic [NW-1:0] n_i;
		logic [DW:0]   rs;

		if (j == 0) begin : g_first
			assign rem_i = '0;
			assign n_i   = num;
			assign d_i   = den;
		end else begin : g_next
			assign rem_i = rem_q[j-1];
			assign n_i   = n_q[j-1];
			assign d_i   = d_q[j-1];
		end

		assign rs = {rem_i, n_i[NW-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				// dividend bits leave at the top, quotient bits enter at the bottom
				if (rs >= {1'b0, d_i}) begin
					rem_q[j] <= DW'(rs - {1'b0, d_i});
					n_q[j]   <= {n_i[NW-2:0], 1'b1};
				end else begin
					rem_q[j] <= DW'(rs);
					n_q[j]   <= {n_i[NW-2:0], 1'b0};
				end
				d_q[j] <= d_i;
			end
		end
	end

	assign quo = n_q[NW-1];

endmodule

FILE: hdl/vec4_arith_unit.sv
// top level of the four-lane fixed-point vector arithmetic unit
// uses v4au_pkg, v4au_lane, v4au_isqrt, v4au_div
// fully pipelined: request in, one result per request out
//
// Four-lane vector ALU on signed fixed-point lanes (WORD_BITS wide, FRAC_BITS
// fraction bits, Q16.16 by default). The opcode picks add, sub, mul or div
// against vector b or against scalar b_x, negate, equal, not equal, length or
// normalize. Out-of-range results saturate and status says so; a divide by
// zero gives the bound with the dividend's sign and status 1, which wins over
// saturation. One request is taken every cycle while the output buffer is not
// full, and every request yields one result. Latency from request to result, at
// Q16.16 as at any other format, is the same for every opcode: every request
// runs through the same pipeline, which is dominated by the square root (one
// root bit per stage) followed by the restoring divider (one quotient bit per
// stage), both needed in series by normalize. A two-entry output buffer lets
// a new request enter while a finished result waits to be taken; requests
// stall only once both entries hold results.
module vec4_arith_unit #(
	parameter int WORD_BITS = v4au_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = v4au_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [3:0]         opcode,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] a_w,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] b_w,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [31:0] r_x,
	output logic signed [31:0] r_y,
	output logic signed [31:0] r_z,
	output logic signed [31:0] r_w,
	output logic               cmp_flag,
	output logic [1:0]         status
);

	localparam int W      = WORD_BITS;
	localparam int F      = FRAC_BITS;
	localparam int L      = v4au_pkg::LANES;
	localparam int SQW    = 2*W + 2;
	localparam int SQ_ST  = W + 1;
	localparam int DV_ST  = W + F;
	localparam int NW     = W + F;
	localparam int NSIDE  = 1 + SQ_ST + DV_ST;
	// stages 1..LAST: input, two lane stages, merge, root, divide
	localparam int LAST   = 4 + SQ_ST + DV_ST;
	localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINM = {1'b1, {(W-1){1'b0}}};

	// per-request information that rides alongside the root and divide stages
	typedef struct packed {
		v4au_pkg::opcode_t    op;
		logic [L-1:0][W-1:0]  res;
		logic                 sat;
		logic                 dz;
		logic                 cmp;
		logic                 ovf;
		logic [L-1:0]         dsgn;
		logic [L-1:0]         usediv;
		logic [L-1:0][W-1:0]  dnum;
		logic [L-1:0][W-1:0]  dden;
	} side_t;

	// ---------------- flow control ----------------
	// the whole pipeline moves together while the output skid entry is free
	logic              en;
	logic [LAST:1]     v_q;
	logic              emit;

	logic              out_v_q, skid_v_q;
	logic [W-1:0]      r_q    [L];
	logic [W-1:0]      r_k_q  [L];
	logic              cmp_q, cmp_k_q;
	v4au_pkg::status_t st_q, st_k_q;

	assign en        = !skid_v_q;
	assign req_ready = en;
	assign emit      = en && v_q[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAST-1:1], req_valid};
		end
	end

	// ---------------- stage 1: request register ----------------
	v4au_pkg::opcode_t op_c, op_s1, op_s2, op_s3;
	logic [W-1:0]      a_c [L];
	logic [W-1:0]      b_c [L];
	logic [W-1:0]      ra_s1 [L];
	logic [W-1:0]      rb_s1 [L];
	logic              scal_c;

	always_comb begin
		op_c   = v4au_pkg::opcode_t'(opcode);
		// lanes take the low WORD_BITS bits of the sign-extended port value
		a_c[0] = W'(64'(a_x));
		a_c[1] = W'(64'(a_y));
		a_c[2] = W'(64'(a_z));
		a_c[3] = W'(64'(a_w));
		scal_c = op_c inside {v4au_pkg::OP_ADDS, v4au_pkg::OP_SUBS,
				v4au_pkg::OP_MULS, v4au_pkg::OP_DIVS};
		b_c[0] = W'(64'(b_x));
		b_c[1] = scal_c ? W'(64'(b_x)) : W'(64'(b_y));
		b_c[2] = scal_c ? W'(64'(b_x)) : W'(64'(b_z));
		b_c[3] = scal_c ? W'(64'(b_x)) : W'(64'(b_w));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op_c;
			for (int i = 0; i < L; i++) begin
				ra_s1[i] <= a_c[i];
				rb_s1[i] <= b_c[i];
			end
		end
	end

	// ---------------- stages 2 and 3: lanes ----------------
	// compare is on raw lane bits across the whole vector
	logic eq_c, cmp_c, cmp_s2, cmp_s3;

	always_comb begin
		eq_c = 1'b1;
		for (int i = 0; i < L; i++) begin
			eq_c = eq_c && (ra_s1[i] == rb_s1[i]);
		end
		case (op_s1)
			v4au_pkg::OP_EQ: cmp_c = eq_c;
			v4au_pkg::OP_NE: cmp_c = !eq_c;
			default:         cmp_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			cmp_s2 <= cmp_c;
			op_s3  <= op_s2;
			cmp_s3 <= cmp_s2;
		end
	end

	logic [W-1:0]         l_res  [L];
	v4au_pkg::lane_flag_t l_flg  [L];
	logic                 l_na   [L];
	logic                 l_nb   [L];
	logic [W-1:0]         l_ma   [L];
	logic [W-1:0]         l_mb   [L];
	logic [2*W-1:0]       l_prod [L];

	for (genvar i = 0; i < L; i++) begin : g_lane
		v4au_lane #(
			.WORD_BITS (W),
			.FRAC_BITS (F)
		) u_lane (
			.clk     (clk),
			.en      (en),
			.op      (op_s1),
			.ra      (ra_s1[i]),
			.rb      (rb_s1[i]),
			.res_s3  (l_res[i]),
			.flg_s3  (l_flg[i]),
			.na_s3   (l_na[i]),
			.nb_s3   (l_nb[i]),
			.ma_s3   (l_ma[i]),
			.mb_s3   (l_mb[i]),
			.prod_s3 (l_prod[i])
		);
	end

	// ---------------- stage 4: merge lanes ----------------
	// sum of squares for length/normalize, per-lane divide setup
	logic [SQW-1:0] sum_c, hsum_c, sq_c, sq_s4;
	logic [2*W-1:0] hsq_c;
	logic           zero_c, carry_c;
	side_t          side0_c;

	always_comb begin
		sum_c   = '0;
		hsum_c  = '0;
		hsq_c   = '0;
		zero_c  = 1'b1;
		side0_c = '0;
		for (int i = 0; i < L; i++) begin
			sum_c  = sum_c + SQW'(l_prod[i]);
			// square of the halved magnitude: (m*m - (odd m ? 2m-1 : 0)) / 4
			hsq_c  = l_prod[i] - (l_ma[i][0]
					? (((2*W)'(l_ma[i]) << 1) - (2*W)'(1)) : '0);
			hsum_c = hsum_c + SQW'(hsq_c >> 2);
			zero_c = zero_c && (l_ma[i] == '0);
		end
		// only reachable at the widest lane format
		carry_c = (sum_c >> v4au_pkg::SUM_LIMIT) != '0;
		// on overflow normalize works on the halved magnitudes
		sq_c = carry_c ? hsum_c : sum_c;

		side0_c.op  = op_s3;
		side0_c.cmp = cmp_s3;
		side0_c.ovf = carry_c;
		for (int i = 0; i < L; i++) begin
			side0_c.res[i]    = l_res[i];
			side0_c.sat       = side0_c.sat | l_flg[i].sat;
			side0_c.dz        = side0_c.dz | l_flg[i].dz;
			side0_c.usediv[i] = ((op_s3 == v4au_pkg::OP_DIV || op_s3 == v4au_pkg::OP_DIVS)
					&& l_mb[i] != '0) || (op_s3 == v4au_pkg::OP_NORM && !zero_c);
			side0_c.dsgn[i]   = (op_s3 == v4au_pkg::OP_NORM) ? l_na[i] : (l_na[i] ^ l_nb[i]);
			side0_c.dnum[i]   = (op_s3 == v4au_pkg::OP_NORM && carry_c) ? (l_ma[i] >> 1)
					: l_ma[i];
			side0_c.dden[i]   = l_mb[i];
		end
		if (op_s3 == v4au_pkg::OP_LEN && carry_c) begin
			side0_c.res[0] = MAXP;
			side0_c.sat    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4 <= sq_c;
		end
	end

	// ---------------- square root stages ----------------
	logic [W:0] root;

	v4au_isqrt #(
		.WORD_BITS (W)
	) u_isqrt (
		.clk  (clk),
		.en   (en),
		.val  (sq_s4),
		.root (root)
	);

	// ---------------- side pipeline ----------------
	// entry 0 is the merge stage, then one entry per root and divide stage
	side_t side_q [NSIDE];
	side_t sidev_c;

	// length result is resolved as the request leaves the root stages
	always_comb begin
		sidev_c = side_q[SQ_ST];
		if (sidev_c.op == v4au_pkg::OP_LEN && !sidev_c.ovf) begin
			if (root > (W+1)'(MAXP)) begin
				sidev_c.res[0] = MAXP;
				sidev_c.sat    = 1'b1;
			end else begin
				sidev_c.res[0] = root[W-1:0];
			end
		end
	end

	for (genvar k = 0; k < NSIDE; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				if (k == 0) begin
					side_q[k] <= side0_c;
				end else if (k == SQ_ST + 1) begin
					side_q[k] <= sidev_c;
				end else begin
					side_q[k] <= side_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	// ---------------- divide stages ----------------
	// normalize divides by the root (at least one), div ops by |b|
	logic [NW-1:0] quo [L];

	for (genvar i = 0; i < L; i++) begin : g_div
		logic [NW-1:0] num_c;
		logic [W:0]    den_c;

		always_comb begin
			num_c = {side_q[SQ_ST].dnum[i], {F{1'b0}}};
			if (side_q[SQ_ST].op == v4au_pkg::OP_NORM) begin
				den_c = (root == '0) ? (W+1)'(1) : root;
			end else begin
				den_c = {1'b0, side_q[SQ_ST].dden[i]};
			end
		end

		v4au_div #(
			.WORD_BITS (W),
			.FRAC_BITS (F)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (num_c),
			.den (den_c),
			.quo (quo[i])
		);
	end

	// ---------------- final pack ----------------
	side_t             sl;
	logic [W-1:0]      rv_c [L];
	logic              qsat_c;
	v4au_pkg::status_t st_c;

	always_comb begin
		sl     = side_q[NSIDE-1];
		qsat_c = 1'b0;
		for (int i = 0; i < L; i++) begin
			rv_c[i] = sl.res[i];
			if (sl.usediv[i]) begin
				if (sl.dsgn[i]) begin
					if (quo[i] > NW'(MINM)) begin
						rv_c[i] = MINM;
						qsat_c  = 1'b1;
					end else begin
						rv_c[i] = -quo[i][W-1:0];
					end
				end else begin
					if (quo[i] > NW'(MAXP)) begin
						rv_c[i] = MAXP;
						qsat_c  = 1'b1;
					end else begin
						rv_c[i] = quo[i][W-1:0];
					end
				end
			end
		end
		// divide by zero takes precedence over saturation
		if (sl.dz) begin
			st_c = v4au_pkg::ST_DIVZ;
		end else if (sl.sat || qsat_c) begin
			st_c = v4au_pkg::ST_SAT;
		end else begin
			st_c = v4au_pkg::ST_OK;
		end
	end

	// ---------------- output register and skid entry ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || res_ready) begin
			out_v_q  <= skid_v_q || emit;
			skid_v_q <= 1'b0;
		end else if (emit) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || res_ready) begin
			if (skid_v_q) begin
				r_q   <= r_k_q;
				cmp_q <= cmp_k_q;
				st_q  <= st_k_q;
			end else begin
				r_q   <= rv_c;
				cmp_q <= sl.cmp;
				st_q  <= st_c;
			end
		end else if (emit) begin
			r_k_q   <= rv_c;
			cmp_k_q <= sl.cmp;
			st_k_q  <= st_c;
		end
	end

	// result lanes are sign-extended from the lane width to the port width
	logic signed [63:0] ext [L];

	always_comb begin
		for (int i = 0; i < L; i++) begin
			ext[i] = 64'(signed'(r_q[i]));
		end
	end

	assign res_valid = out_v_q;
	assign r_x       = ext[0][v4au_pkg::PORT_BITS-1:0];
	assign r_y       = ext[1][v4au_pkg::PORT_BITS-1:0];
	assign r_z       = ext[2][v4au_pkg::PORT_BITS-1:0];
	assign r_w       = ext[3][v4au_pkg::PORT_BITS-1:0];
	assign cmp_flag  = cmp_q;
	assign status    = st_q;

endmodule
